// ===== rtl/triangle_face_normal_defines.svh =====
// assertion macros shared by the triangle face normal rtl
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// implication checked in the same cycle, idle during reset
`define TFN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked a fixed number of cycles later
`define TFN_ASSERT_DLY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== rtl/tfn_pkg.sv =====
// shared types and constants of the triangle face normal pipeline
package tfn_pkg;

  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = 31;
  localparam int LEN_W     = 6;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int FRAC_BITS = 14;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
  localparam int OUT_W     = 16;

  localparam int CROSS_STAGES = 4;
  localparam int SCALE_STAGES = 4;
  localparam int DIV_STAGES   = Q_W + 1;
  localparam int LATENCY      = CROSS_STAGES + SCALE_STAGES + ROOT_W + DIV_STAGES + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p1_z;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p2_z;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic signed [COORD_W-1:0] p3_z;
  } tfn_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } tfn_out_t;

  typedef struct packed {
    logic       valid;
    logic       degenerate;
    logic [2:0] neg;
  } tfn_ctl_t;

  typedef logic [2:0][CROSS_W-1:0] tfn_wide3_t;
  typedef logic [2:0][MAG_W-1:0]   tfn_mag3_t;
  typedef logic [2:0][Q_W-1:0]     tfn_q3_t;

endpackage

// ===== rtl/tfn_cross.sv =====
// edge vectors, cross product and component magnitudes
module tfn_cross (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tfn_pkg::tfn_in_t   triangle,
  output tfn_pkg::tfn_ctl_t  ctl,
  output tfn_pkg::tfn_wide3_t mag
);
  import tfn_pkg::*;

  logic                     v1, v2, v3;
  logic signed [DIFF_W-1:0]  a [3];
  logic signed [DIFF_W-1:0]  b [3];
  logic signed [PROD_W-1:0]  prod [6];
  logic signed [CROSS_W-1:0] c [3];

  // stage 1: edges from the second vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    a[0] <= $signed({triangle.p3_x[COORD_W-1], triangle.p3_x})
          - $signed({triangle.p2_x[COORD_W-1], triangle.p2_x});
    a[1] <= $signed({triangle.p3_y[COORD_W-1], triangle.p3_y})
          - $signed({triangle.p2_y[COORD_W-1], triangle.p2_y});
    a[2] <= $signed({triangle.p3_z[COORD_W-1], triangle.p3_z})
          - $signed({triangle.p2_z[COORD_W-1], triangle.p2_z});
    b[0] <= $signed({triangle.p1_x[COORD_W-1], triangle.p1_x})
          - $signed({triangle.p2_x[COORD_W-1], triangle.p2_x});
    b[1] <= $signed({triangle.p1_y[COORD_W-1], triangle.p1_y})
          - $signed({triangle.p2_y[COORD_W-1], triangle.p2_y});
    b[2] <= $signed({triangle.p1_z[COORD_W-1], triangle.p1_z})
          - $signed({triangle.p2_z[COORD_W-1], triangle.p2_z});
  end

  // stage 2: six partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    prod[0] <= a[1] * b[2];
    prod[1] <= a[2] * b[1];
    prod[2] <= a[2] * b[0];
    prod[3] <= a[0] * b[2];
    prod[4] <= a[0] * b[1];
    prod[5] <= a[1] * b[0];
  end

  // stage 3: cross product
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    c[0] <= CROSS_W'(prod[0]) - CROSS_W'(prod[1]);
    c[1] <= CROSS_W'(prod[2]) - CROSS_W'(prod[3]);
    c[2] <= CROSS_W'(prod[4]) - CROSS_W'(prod[5]);
  end

  // stage 4: sign, magnitude, zero vector flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= v3;
    end
    ctl.degenerate <= (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
    for (int i = 0; i < 3; i++) begin
      ctl.neg[i] <= c[i][CROSS_W-1];
      mag[i]     <= c[i][CROSS_W-1] ? CROSS_W'(-c[i]) : CROSS_W'(c[i]);
    end
  end

endmodule

// ===== rtl/tfn_scale.sv =====
// magnitude normalization and sum of squares
module tfn_scale (
  input  logic                clk,
  input  logic                rst,
  input  tfn_pkg::tfn_ctl_t   ctl_in,
  input  tfn_pkg::tfn_wide3_t mag_in,
  output tfn_pkg::tfn_ctl_t   ctl,
  output tfn_pkg::tfn_mag3_t  mag,
  output logic [tfn_pkg::SUM_W-1:0] sum
);
  import tfn_pkg::*;

  function automatic logic [LEN_W-1:0] bit_length(input logic [CROSS_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < CROSS_W; i++) begin
      if (v[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

  tfn_ctl_t         ctl5, ctl6, ctl7;
  tfn_wide3_t       mag5;
  logic [LEN_W-1:0] len5;
  tfn_mag3_t        mag6, mag7;
  logic [SQ_W-1:0]  sq [3];

  // stage 5: bit length of the largest magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5 <= '0;
    end else begin
      ctl5 <= ctl_in;
    end
    mag5 <= mag_in;
    len5 <= bit_length(mag_in[0] | mag_in[1] | mag_in[2]);
  end

  // stage 6: largest magnitude lands in [2^30, 2^31)
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl6 <= '0;
    end else begin
      ctl6 <= ctl5;
    end
    for (int i = 0; i < 3; i++) begin
      mag6[i] <= MAG_W'({mag5[i], {MAG_W{1'b0}}} >> len5);
    end
  end

  // stage 7: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl7 <= '0;
    end else begin
      ctl7 <= ctl6;
    end
    mag7 <= mag6;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= mag6[i] * mag6[i];
    end
  end

  // stage 8: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl7;
    end
    mag <= mag7;
    sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  end

endmodule

// ===== rtl/tfn_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module tfn_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  tfn_pkg::tfn_ctl_t         ctl_in,
  input  tfn_pkg::tfn_mag3_t        mag_in,
  input  logic [tfn_pkg::SUM_W-1:0] sum,
  output tfn_pkg::tfn_ctl_t         ctl,
  output tfn_pkg::tfn_mag3_t        mag,
  output logic [tfn_pkg::ROOT_W-1:0] root
);
  import tfn_pkg::*;

  tfn_ctl_t         ctl_s  [ROOT_W+1];
  tfn_mag3_t        mag_s  [ROOT_W+1];
  logic [SUM_W-1:0] rem_s  [ROOT_W+1];
  logic [SUM_W-1:0] root_s [ROOT_W+1];

  assign ctl_s[0]  = ctl_in;
  assign mag_s[0]  = mag_in;
  assign rem_s[0]  = sum;
  assign root_s[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W:0] trial;
    assign trial = {1'b0, root_s[k]} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k+1] <= '0;
      end else begin
        ctl_s[k+1] <= ctl_s[k];
      end
      mag_s[k+1] <= mag_s[k];
      if ({1'b0, rem_s[k]} >= trial) begin
        rem_s[k+1]  <= rem_s[k] - trial[SUM_W-1:0];
        root_s[k+1] <= (root_s[k] >> 1) + BIT;
      end else begin
        rem_s[k+1]  <= rem_s[k];
        root_s[k+1] <= root_s[k] >> 1;
      end
    end
  end

  assign ctl  = ctl_s[ROOT_W];
  assign mag  = mag_s[ROOT_W];
  assign root = root_s[ROOT_W][ROOT_W-1:0];

endmodule

// ===== rtl/tfn_div.sv =====
// pipelined rounded division of each magnitude by the length
module tfn_div (
  input  logic                       clk,
  input  logic                       rst,
  input  tfn_pkg::tfn_ctl_t          ctl_in,
  input  tfn_pkg::tfn_mag3_t         mag_in,
  input  logic [tfn_pkg::ROOT_W-1:0] len,
  output tfn_pkg::tfn_ctl_t          ctl,
  output tfn_pkg::tfn_q3_t           quo
);
  import tfn_pkg::*;

  tfn_ctl_t          ctl_s [Q_W+1];
  logic [ROOT_W-1:0] len_s [Q_W+1];
  logic [NUM_W-1:0]  rem_s [Q_W+1][3];
  tfn_q3_t           q_s   [Q_W+1];

  // numerator with half the divisor added for round half up
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0] <= '0;
    end else begin
      ctl_s[0] <= ctl_in;
    end
    len_s[0] <= len;
    q_s[0]   <= '0;
    for (int i = 0; i < 3; i++) begin
      rem_s[0][i] <= NUM_W'({mag_in[i], {FRAC_BITS{1'b0}}}) + NUM_W'(len >> 1);
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int SH = Q_W - 1 - j;
    logic [NUM_W:0] dvs;
    assign dvs = (NUM_W + 1)'(len_s[j]) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[j+1] <= '0;
      end else begin
        ctl_s[j+1] <= ctl_s[j];
      end
      len_s[j+1] <= len_s[j];
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, rem_s[j][i]} >= dvs) begin
          rem_s[j+1][i] <= rem_s[j][i] - dvs[NUM_W-1:0];
          q_s[j+1][i]   <= {q_s[j][i][Q_W-2:0], 1'b1};
        end else begin
          rem_s[j+1][i] <= rem_s[j][i];
          q_s[j+1][i]   <= {q_s[j][i][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign ctl = ctl_s[Q_W];
  assign quo = q_s[Q_W];

endmodule

// ===== rtl/triangle_face_normal.sv =====
// top level of the triangle unit face normal pipeline
//
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------
// input    | start, busy        | triangle: three Q16.8 vertices
// result   | done (one cycle)   | result: Q1.14 normal, degenerate flag
//
// one transaction accepted per cycle when start is high and busy is low
// every transaction gives one result, passing in order through the stages
// of edge and cross product, of scaling and sum of squares, of the
// square root (one root bit per stage), of division (numerator setup
// plus one quotient bit per stage) and through one output register
// synchronous reset empties the pipeline; busy is high only during reset
// the receiver cannot stall, so the pipeline never holds and never drops
`include "triangle_face_normal_defines.svh"

module triangle_face_normal (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tfn_pkg::tfn_in_t  triangle,
  output logic              done,
  output tfn_pkg::tfn_out_t result
);
  import tfn_pkg::*;

  // stage groups
  tfn_ctl_t          cross_ctl, scale_ctl, sqrt_ctl, div_ctl;
  tfn_wide3_t        cross_mag;
  tfn_mag3_t         scale_mag, sqrt_mag;
  logic [SUM_W-1:0]  scale_sum;
  logic [ROOT_W-1:0] sqrt_root;
  tfn_q3_t           div_quo;
  logic              accept;

  // no transaction is taken while reset holds the pipeline clear
  assign busy   = rst;
  assign accept = start && !busy;

  // edges, cross product, magnitudes
  tfn_cross u_cross (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .triangle (triangle),
    .ctl      (cross_ctl),
    .mag      (cross_mag)
  );

  // normalize to 31 bits and form the squared length
  tfn_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (cross_ctl),
    .mag_in (cross_mag),
    .ctl    (scale_ctl),
    .mag    (scale_mag),
    .sum    (scale_sum)
  );

  // length = floor(sqrt(sum))
  tfn_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (scale_ctl),
    .mag_in (scale_mag),
    .sum    (scale_sum),
    .ctl    (sqrt_ctl),
    .mag    (sqrt_mag),
    .root   (sqrt_root)
  );

  // rounded magnitude * 2^14 / length
  tfn_div u_div (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (sqrt_ctl),
    .mag_in (sqrt_mag),
    .len    (sqrt_root),
    .ctl    (div_ctl),
    .quo    (div_quo)
  );

  // output register: apply sign, force zero vector on degenerate input
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_ctl.valid;
    end
    result.degenerate <= div_ctl.degenerate;
    if (div_ctl.degenerate) begin
      result.normal_x <= '0;
      result.normal_y <= '0;
      result.normal_z <= '0;
    end else begin
      result.normal_x <= div_ctl.neg[0] ? -OUT_W'(div_quo[0]) : OUT_W'(div_quo[0]);
      result.normal_y <= div_ctl.neg[1] ? -OUT_W'(div_quo[1]) : OUT_W'(div_quo[1]);
      result.normal_z <= div_ctl.neg[2] ? -OUT_W'(div_quo[2]) : OUT_W'(div_quo[2]);
    end
  end

  // fixed latency from accepted transaction to result strobe
  `TFN_ASSERT_DLY(a_latency, accept, LATENCY, done, "result strobe missing after fixed latency")
  // degenerate results carry a zero vector
  `TFN_ASSERT_IMP(a_degen_zero, done && result.degenerate, result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0, "degenerate result with nonzero normal")
  // a unit vector always has a nonzero component
  `TFN_ASSERT_IMP(a_unit_nonzero, done && !result.degenerate, result.normal_x != '0 || result.normal_y != '0 || result.normal_z != '0, "zero normal without degenerate flag")

endmodule

// ===== bench/triangle_face_normal_test.sv =====
// self-checking testbench of the triangle unit face normal pipeline
module triangle_face_normal_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tfn_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  tfn_in_t  triangle = '0;
  logic     done;
  tfn_out_t result;

  // normals still in flight, oldest first
  tfn_out_t pending_normals[$];
  int       mismatch_count = 0;
  int       normals_seen = 0;
  int       degenerate_seen = 0;
  int       triangles_sent = 0;
  int       sender_idle_pct = 0;

  localparam int MAX_C = 8388607;
  localparam int MIN_C = -8388608;

  triangle_face_normal u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .triangle (triangle),
    .done     (done),
    .result   (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bit-by-bit root of a 64-bit value
  function automatic logic [63:0] root_of(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = v;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // unit face normal of one triangle, p2 taken as origin
  function automatic tfn_out_t face_normal(tfn_in_t t);
    tfn_out_t    n;
    longint      ax, ay, az, bx, by, bz;
    longint      cr[3];
    logic [63:0] mg[3];
    logic [63:0] mx, sum, len, q;
    int          blen;
    ax = longint'(t.p3_x) - longint'(t.p2_x);
    ay = longint'(t.p3_y) - longint'(t.p2_y);
    az = longint'(t.p3_z) - longint'(t.p2_z);
    bx = longint'(t.p1_x) - longint'(t.p2_x);
    by = longint'(t.p1_y) - longint'(t.p2_y);
    bz = longint'(t.p1_z) - longint'(t.p2_z);
    cr[0] = ay * bz - az * by;
    cr[1] = az * bx - ax * bz;
    cr[2] = ax * by - ay * bx;
    n = '0;
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      n.degenerate = 1'b1;
      return n;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
      if (mg[i] > mx) mx = mg[i];
    end
    blen = 0;
    while (mx != 0) begin
      mx = mx >> 1;
      blen++;
    end
    for (int i = 0; i < 3; i++) begin
      if (blen < 31) mg[i] = mg[i] << (31 - blen);
      else mg[i] = mg[i] >> (blen - 31);
    end
    sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    len = root_of(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (mg[i] * 64'd16384 + (len >> 1)) / len;
      if (q > 64'd16384) q = 64'd16384;
      if (cr[i] < 0) q = -q;
      if (i == 0) n.normal_x = q[15:0];
      else if (i == 1) n.normal_y = q[15:0];
      else n.normal_z = q[15:0];
    end
    return n;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatch_count++;
  endtask

  // one transaction, with optional idle cycles before it
  task automatic send_triangle(tfn_in_t t, bit has_known, tfn_out_t known);
    tfn_out_t pred;
    while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    pred = face_normal(t);
    if (has_known) begin
      if (pred.normal_x != known.normal_x)
        report_mismatch("typed normal_x", pred.normal_x, known.normal_x);
      if (pred.normal_y != known.normal_y)
        report_mismatch("typed normal_y", pred.normal_y, known.normal_y);
      if (pred.normal_z != known.normal_z)
        report_mismatch("typed normal_z", pred.normal_z, known.normal_z);
      if (pred.degenerate != known.degenerate)
        report_mismatch("typed degenerate", int'(pred.degenerate), int'(known.degenerate));
    end
    start <= 1'b1;
    triangle <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_normals.push_back(pred);
    triangles_sent++;
  endtask

  function automatic tfn_in_t make_tri(int c[9]);
    tfn_in_t t;
    t.p1_x = COORD_W'(c[0]); t.p1_y = COORD_W'(c[1]); t.p1_z = COORD_W'(c[2]);
    t.p2_x = COORD_W'(c[3]); t.p2_y = COORD_W'(c[4]); t.p2_z = COORD_W'(c[5]);
    t.p3_x = COORD_W'(c[6]); t.p3_y = COORD_W'(c[7]); t.p3_z = COORD_W'(c[8]);
    return t;
  endfunction

  function automatic int rand_coord(int mode);
    case (mode)
      0: return int'($urandom_range(511, 0)) - 256;
      1: return $urandom_range(1, 0) ? MAX_C : MIN_C;
      default: return int'({{8{1'b0}}, 24'($urandom)} ^ 32'h800000) - 32'h800000;
    endcase
  endfunction

  // directed rows: coordinates and, where obvious, the normal
  typedef struct {
    int       c[9];
    bit       has_known;
    tfn_out_t known;
  } tri_row_t;

  tri_row_t dir_rows[] = '{
    // all zero: degenerate
    '{'{0,0,0, 0,0,0, 0,0,0}, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    // collinear points: degenerate
    '{'{256,256,256, 0,0,0, 512,512,512}, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    // p1 equal to p2: degenerate
    '{'{5,6,7, 5,6,7, 100,-3,9}, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
    // a along y, b along x: normal is -z
    '{'{256,0,0, 0,0,0, 0,256,0}, 1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    // swapped winding: +z
    '{'{0,256,0, 0,0,0, 256,0,0}, 1, '{16'sd0, 16'sd0, 16'sd16384, 1'b0}},
    // normal along x
    '{'{0,0,256, 0,0,0, 0,256,0}, 1, '{16'sd16384, 16'sd0, 16'sd0, 1'b0}},
    // normal along y
    '{'{256,0,0, 0,0,0, 0,0,256}, 1, '{16'sd0, 16'sd16384, 16'sd0, 1'b0}},
    // smallest nonzero cross product
    '{'{1,0,0, 0,0,0, 0,1,0}, 1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    // extreme coordinates, largest edges, then one small triangle
    '{'{MAX_C,MIN_C,MIN_C, MIN_C,MIN_C,MIN_C, MIN_C,MAX_C,MIN_C}, 0, '0},
    '{'{MIN_C,MAX_C,MAX_C, MAX_C,MAX_C,MAX_C, MAX_C,MIN_C,MAX_C}, 0, '0},
    '{'{MAX_C,MAX_C,MAX_C, MIN_C,MIN_C,MIN_C, MAX_C,MIN_C,MAX_C}, 0, '0},
    '{'{MIN_C,MAX_C,MIN_C, MAX_C,MIN_C,MAX_C, MIN_C,MIN_C,MAX_C}, 0, '0},
    '{'{-1,-1,-1, 0,0,0, 1,-1,1}, 0, '0},
    // diagonal normals, rounding ties
    '{'{256,0,0, 0,0,0, 0,256,256}, 0, '0},
    '{'{256,-256,0, 0,0,0, 0,256,-256}, 0, '0},
    '{'{3,1,0, 0,0,0, 1,2,5}, 0, '0},
    '{'{-8388608,0,0, 8388607,0,0, 8388607,1,0}, 0, '0}
  };

  // result side: the strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        tfn_out_t want;
        want = pending_normals.pop_front();
        if (result.normal_x !== want.normal_x)
          report_mismatch("normal_x", result.normal_x, want.normal_x);
        if (result.normal_y !== want.normal_y)
          report_mismatch("normal_y", result.normal_y, want.normal_y);
        if (result.normal_z !== want.normal_z)
          report_mismatch("normal_z", result.normal_z, want.normal_z);
        if (result.degenerate !== want.degenerate)
          report_mismatch("degenerate", result.degenerate, want.degenerate);
        normals_seen++;
        if (want.degenerate) degenerate_seen++;
      end
    end
  end

  // stimulus
  initial begin
    int c[9];
    int mode;
    int wait_cycles;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_triangle(make_tri(dir_rows[i].c), dir_rows[i].has_known, dir_rows[i].known);

    // random phases: sender idle percentage per phase
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = (phase == 1 || phase == 3) ? 72 : (phase == 2 ? 24 : 0);
      for (int k = 0; k < 200; k++) begin
        mode = $urandom_range(9, 0);
        for (int j = 0; j < 9; j++)
          c[j] = rand_coord(mode < 3 ? 0 : (mode == 3 ? 1 : 2));
        // occasional degenerate triangle: p1 on the line through p2 and p3
        if (mode == 4) begin
          c[0] = c[3]; c[1] = c[4]; c[2] = c[5];
        end
        send_triangle(make_tri(c), 0, '0);
      end
      // drop start; after phase 1 only, hold off until the pipeline drains
      start <= 1'b0;
      if (phase == 1) while (pending_normals.size() != 0) @(posedge clk);
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (pending_normals.size() != 0 && wait_cycles < 10 * LATENCY) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    $display("sent %0d triangles, checked %0d normals (%0d degenerate)",
             triangles_sent, normals_seen, degenerate_seen);
    $display("covered extreme coordinates, axis normals and sender idle phases");
    if (mismatch_count == 0 && pending_normals.size() == 0) begin
      $display("triangle_face_normal_test OK");
    end else begin
      $display("triangle_face_normal_test NOT OK");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #2ms;
    $display("triangle_face_normal_test NOT OK");
    $finish;
  end
endmodule
